/* rtl/vdm_pkg.sv */
// ----------------------------------------------------------------------------
// Vector distance metric package
// Shared widths, codes, payload structs and the job record that passes
// from the accumulating front end to the scoring back end.
// ----------------------------------------------------------------------------
package vdm_pkg;

  localparam int MAX_LEN     = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int ACC_W       = 48;
  localparam int CNT_W       = 13;
  localparam int SCORE_W     = 32;
  localparam int NUM_W       = 96;
  localparam int DEN_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [1:0] METRIC_MAE = 2'd0;
  localparam logic [1:0] METRIC_MSE = 2'd1;
  localparam logic [1:0] METRIC_COS = 2'd2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value_a;
    logic signed [SAMPLE_W-1:0] value_b;
    logic                       last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      status;
    logic [CNT_W-1:0]          element_count;
  } out_item_t;

  typedef struct packed {
    logic             is_cos;
    logic             is_mse;
    logic [ACC_W-1:0] diff_sum;
    logic [ACC_W-1:0] norm_a;
    logic [ACC_W-1:0] norm_b;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

/* rtl/vector_distance_metric.sv */
// A cosine job with a zero norm skips the square roots and the divider.
// Throughput: one element pair per cycle while the job queue has room;
// the back end scores one job at a time, paced by the 96-step divider
// and, for cosine, the 32-step square roots.
// Reset: synchronous active-low rst_n clears the sums, queue and selector.
// ----------------------------------------------------------------------------
// Vector distance metric
// Streams element pairs, accumulates sums and scores each vector as mean absolute
// error in Q19.13, mean squared error divided by four, or cosine similarity in Q4.28.
// ----------------------------------------------------------------------------
module vector_distance_metric import vdm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  // The front end takes a transaction every cycle the job queue has room.
  // A transaction marked last pushes its finished sums as one job; the
  // back end pops jobs one at a time and holds each result in its output
  // register, so the next vector accumulates while a score is computed.
  queue_stat_t q_stat;
  logic        push, pop;
  job_t        push_job, pop_job;

  vdm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .push        (push),
    .push_job    (push_job)
  );

  vdm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // The back end sees a job whenever the queue is not empty.
  vdm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (!q_stat.empty),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A zero-norm status always carries a zero score.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.score == '0)
    else $error("zero norm result with nonzero score");

  // Every reported vector holds between one and the maximum number of pairs.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.element_count != '0 &&
                  out_data.element_count <= CNT_W'(MAX_LEN))
    else $error("element count out of range");

  // The queue can never look full and empty at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("job queue status inconsistent");

  // The input side only stalls because the queue is full.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_stat.full)
    else $error("input stalled with room in queue");

endmodule

/* rtl/vdm_front.sv */
// ----------------------------------------------------------------------------
// Vector distance metric front end
// Accumulates one element pair per cycle while the job queue has room and
// hands a finished vector to the job queue.
// ----------------------------------------------------------------------------
module vdm_front import vdm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  queue_stat_t q_stat,
  output logic        push,
  output job_t        push_job
);

  logic [1:0]              metric_r;
  logic [ACC_W-1:0]        diff_r, norm_a_r, norm_b_r;
  logic [CNT_W-1:0]        count_r;
  logic signed [16:0]      diff;
  logic [16:0]             abs_d;
  logic signed [31:0]      prod_ab, prod_aa, prod_bb;
  logic signed [33:0]      prod_dd;
  logic [ACC_W-1:0]        add_v, diff_upd, norm_a_upd, norm_b_upd;
  logic [CNT_W-1:0]        count_upd;
  logic                    is_cos, is_mse, room, accept;

  always_comb begin
    diff    = {in_data.value_a[15], in_data.value_a} - {in_data.value_b[15], in_data.value_b};
    abs_d   = diff[16] ? 17'(-diff) : 17'(diff);
    prod_ab = in_data.value_a * in_data.value_b;
    prod_aa = in_data.value_a * in_data.value_a;
    prod_bb = in_data.value_b * in_data.value_b;
    prod_dd = diff * diff;
    // Bit 1 of the selector picks the cosine, so code three behaves as cosine.
    is_cos  = metric_r[1];
    is_mse  = (metric_r == METRIC_MSE);
    if (is_cos) begin
      add_v = {{16{prod_ab[31]}}, prod_ab};
    end else if (is_mse) begin
      add_v = {15'b0, prod_dd[32:0]};
    end else begin
      add_v = {31'b0, abs_d};
    end
    room       = (count_r < CNT_W'(MAX_LEN));
    diff_upd   = room ? diff_r + add_v : diff_r;
    norm_a_upd = room ? norm_a_r + {16'b0, prod_aa} : norm_a_r;
    norm_b_upd = room ? norm_b_r + {16'b0, prod_bb} : norm_b_r;
    count_upd  = room ? count_r + CNT_W'(1) : count_r;
  end

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && in_data.last_element;

  always_comb begin
    push_job.is_cos   = is_cos;
    push_job.is_mse   = is_mse;
    push_job.diff_sum = diff_upd;
    push_job.norm_a   = norm_a_upd;
    push_job.norm_b   = norm_b_upd;
    push_job.count    = count_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= METRIC_MAE;
      diff_r   <= '0;
      norm_a_r <= '0;
      norm_b_r <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        metric_r <= cfg_wr_data;
      end
      if (accept) begin
        if (in_data.last_element) begin
          diff_r   <= '0;
          norm_a_r <= '0;
          norm_b_r <= '0;
          count_r  <= '0;
        end else begin
          diff_r   <= diff_upd;
          norm_a_r <= norm_a_upd;
          norm_b_r <= norm_b_upd;
          count_r  <= count_upd;
        end
      end
    end
  end

endmodule

/* rtl/vdm_queue.sv */
// ----------------------------------------------------------------------------
// Vector distance metric job queue
// Two-entry queue of finished vector sums between front and back end.
// ----------------------------------------------------------------------------
module vdm_queue import vdm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  job_t        push_job,
  input  logic        pop,
  output job_t        pop_job,
  output queue_stat_t q_stat
);

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign q_stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_job      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/vdm_back.sv */
// ----------------------------------------------------------------------------
// Vector distance metric back end
// Turns one job into a score by one-bit-per-cycle restoring division, for
// cosine after two bit-pair square roots and a multiply; holds it until taken.
// ----------------------------------------------------------------------------
module vdm_back import vdm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  input  job_t      pop_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_ROOT, ST_MUL, ST_DIV, ST_DONE} state_t;

  state_t            state_r;
  logic              out_valid_r;
  out_item_t         out_r;
  logic [6:0]        iter_r;
  logic              neg_r, ovf_r;
  logic [CNT_W-1:0]  count_r;
  logic [63:0]       xa_r, xb_r;
  logic [33:0]       ra_rem_r, rb_rem_r;
  logic [ROOT_W-1:0] ra_r, rb_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r, rem_r;
  logic [SCORE_W-1:0] q_r;

  logic [35:0]       ra_sh, rb_sh, ra_try, rb_try;
  logic              ra_ge, rb_ge, d_ge, ovf_fin;
  logic [64:0]       d_sh;
  logic [DEN_W-1:0]  rem_nxt, prod;
  logic [SCORE_W-1:0] q_nxt, q_sat;
  logic [CNT_W-1:0]  cnt_div;
  logic [ACC_W-1:0]  mag;

  always_comb begin
    ra_sh   = {ra_rem_r, xa_r[63:62]};
    rb_sh   = {rb_rem_r, xb_r[63:62]};
    ra_try  = {2'b0, ra_r, 2'b01};
    rb_try  = {2'b0, rb_r, 2'b01};
    ra_ge   = (ra_sh >= ra_try);
    rb_ge   = (rb_sh >= rb_try);
    d_sh    = {rem_r, num_r[NUM_W-1]};
    d_ge    = (d_sh >= {1'b0, den_r});
    rem_nxt = d_ge ? 64'(d_sh - {1'b0, den_r}) : 64'(d_sh);
    q_nxt   = {q_r[SCORE_W-2:0], d_ge};
    ovf_fin = ovf_r | q_r[SCORE_W-1] | q_nxt[SCORE_W-1];
    q_sat   = ovf_fin ? SCORE_MAX : q_nxt;
    prod    = {32'b0, ra_r} * {32'b0, rb_r};
    cnt_div = (pop_job.count == '0) ? CNT_W'(1) : pop_job.count;
    mag     = pop_job.diff_sum[ACC_W-1] ? ACC_W'(-pop_job.diff_sum) : pop_job.diff_sum;
  end

  assign pop       = (state_r == ST_IDLE) && pop_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            count_r  <= pop_job.count;
            iter_r   <= '0;
            q_r      <= '0;
            ovf_r    <= 1'b0;
            rem_r    <= '0;
            ra_r     <= '0;
            rb_r     <= '0;
            ra_rem_r <= '0;
            rb_rem_r <= '0;
            neg_r    <= pop_job.is_cos && pop_job.diff_sum[ACC_W-1];
            if (pop_job.is_cos) begin
              if (pop_job.norm_a == '0 || pop_job.norm_b == '0) begin
                out_r.score         <= '0;
                out_r.status        <= 1'b1;
                out_r.element_count <= pop_job.count;
                out_valid_r         <= 1'b1;
                state_r             <= ST_DONE;
              end else begin
                xa_r    <= {1'b0, pop_job.norm_a[42:0], 20'b0};
                xb_r    <= {1'b0, pop_job.norm_b[42:0], 20'b0};
                num_r   <= {mag, 48'b0};
                state_r <= ST_ROOT;
              end
            end else if (pop_job.is_mse) begin
              num_r   <= {48'b0, pop_job.diff_sum};
              den_r   <= {49'b0, cnt_div, 2'b0};
              state_r <= ST_DIV;
            end else begin
              num_r   <= {35'b0, pop_job.diff_sum, 13'b0};
              den_r   <= {51'b0, cnt_div};
              state_r <= ST_DIV;
            end
          end
        end
        ST_ROOT: begin
          xa_r     <= {xa_r[61:0], 2'b0};
          xb_r     <= {xb_r[61:0], 2'b0};
          ra_rem_r <= ra_ge ? 34'(ra_sh - ra_try) : 34'(ra_sh);
          rb_rem_r <= rb_ge ? 34'(rb_sh - rb_try) : 34'(rb_sh);
          ra_r     <= {ra_r[ROOT_W-2:0], ra_ge};
          rb_r     <= {rb_r[ROOT_W-2:0], rb_ge};
          iter_r   <= iter_r + 7'd1;
          if (iter_r == 7'(ROOT_W - 1)) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          den_r   <= (prod == '0) ? DEN_W'(1) : prod;
          iter_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          num_r  <= {num_r[NUM_W-2:0], 1'b0};
          rem_r  <= rem_nxt;
          q_r    <= q_nxt;
          ovf_r  <= ovf_r | q_r[SCORE_W-1];
          iter_r <= iter_r + 7'd1;
          if (iter_r == 7'(NUM_W - 1)) begin
            out_r.score         <= neg_r ? -$signed(q_sat) : $signed(q_sat);
            out_r.status        <= 1'b0;
            out_r.element_count <= count_r;
            out_valid_r         <= 1'b1;
            state_r             <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
